[hdl/dfr_pkg.sv]
// Shared types and constants of the dielectric Fresnel reflectance pipeline.
package dfr_pkg;

  localparam int DIV_STAGES  = 31;
  localparam int SQRT_STAGES = 16;
  localparam int SIDE_A_LEN  = DIV_STAGES + SQRT_STAGES;

  localparam logic [15:0] ONE_Q15      = 16'h8000;
  localparam logic [15:0] ETA_I_RESET  = 16'd4096;
  localparam logic [15:0] ETA_T_RESET  = 16'd6144;

  localparam logic [1:0] REG_ETA_INCIDENT    = 2'd0;
  localparam logic [1:0] REG_ETA_TRANSMITTED = 2'd1;

  // Data that travels beside the transmitted-cosine divider and square root.
  typedef struct packed {
    logic [16:0] c;
    logic [15:0] ni;
    logic [15:0] nt;
    logic        tir;
  } side_a_t;

  // Data that travels beside the two ratio dividers.
  typedef struct packed {
    logic tir;
    logic zs;
    logic zp;
  } side_b_t;

endpackage

[hdl/dfr_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
module dfr_div import dfr_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [33:0] rem_in,
  input  logic [30:0] lo_in,
  input  logic [33:0] dvs_in,
  output logic [30:0] q_out
);

  logic [33:0] rem [1:DIV_STAGES];
  logic [30:0] lo  [1:DIV_STAGES];
  logic [33:0] dvs [1:DIV_STAGES];
  logic [30:0] q   [1:DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [33:0] rem_p;
    logic [30:0] lo_p;
    logic [33:0] dvs_p;
    logic [30:0] q_p;
    logic [34:0] trial;
    logic [35:0] diff;

    if (k == 0) begin : g_first
      assign rem_p = rem_in;
      assign lo_p  = lo_in;
      assign dvs_p = dvs_in;
      assign q_p   = '0;
    end else begin : g_rest
      assign rem_p = rem[k];
      assign lo_p  = lo[k];
      assign dvs_p = dvs[k];
      assign q_p   = q[k];
    end

    assign trial = {rem_p, lo_p[30]};
    assign diff  = {1'b0, trial} - {2'b00, dvs_p};

    always_ff @(posedge clk) begin
      if (en) begin
        if (!diff[35]) begin
          rem[k+1] <= diff[33:0];
          q[k+1]   <= {q_p[29:0], 1'b1};
        end else begin
          rem[k+1] <= trial[33:0];
          q[k+1]   <= {q_p[29:0], 1'b0};
        end
        lo[k+1]  <= {lo_p[29:0], 1'b0};
        dvs[k+1] <= dvs_p;
      end
    end
  end

  assign q_out = q[DIV_STAGES];

endmodule

[hdl/dfr_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
module dfr_sqrt import dfr_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [30:0] v_in,
  output logic [15:0] root_out
);

  logic [31:0] v    [1:SQRT_STAGES];
  logic [31:0] root [1:SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    localparam logic [31:0] BIT = 32'h1 << (30 - 2 * k);
    logic [31:0] v_p;
    logic [31:0] root_p;
    logic [31:0] trial;

    if (k == 0) begin : g_first
      assign v_p    = {1'b0, v_in};
      assign root_p = '0;
    end else begin : g_rest
      assign v_p    = v[k];
      assign root_p = root[k];
    end

    assign trial = root_p + BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        if (v_p >= trial) begin
          v[k+1]    <= v_p - trial;
          root[k+1] <= (root_p >> 1) + BIT;
        end else begin
          v[k+1]    <= v_p;
          root[k+1] <= root_p >> 1;
        end
      end
    end
  end

  assign root_out = root[SQRT_STAGES][15:0];

endmodule

[hdl/dielectric_fresnel_reflectance.sv]
// Throughput: one word per cycle; the pipeline advances as one whole unless
// the output register holds a word that is stalled.
// Depth is set by two 31-stage bit-serial dividers and a 16-stage square root.
// Reset (synchronous) empties every stage and loads the index registers with
// 1.0 on the incident side and 1.5 on the transmitted side.
module dielectric_fresnel_reflectance import dfr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               cos_valid,
  output logic               cos_stall,
  input  logic signed [15:0] cos_incident,
  output logic               refl_valid,
  input  logic               refl_stall,
  output logic [15:0]        reflectance,
  output logic               total_reflection
);

  // Configuration registers.
  logic [15:0] eta_incident;
  logic [15:0] eta_transmitted;

  always_ff @(posedge clk) begin
    if (rst) begin
      eta_incident    <= ETA_I_RESET;
      eta_transmitted <= ETA_T_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ETA_INCIDENT:    eta_incident    <= cfg_data;
        REG_ETA_TRANSMITTED: eta_transmitted <= cfg_data;
        default: ;
      endcase
    end
  end

  // The whole pipeline moves together. It stands still only when the output
  // register holds a word that the consumer is not taking.
  logic adv;
  assign adv       = !refl_valid || !refl_stall;
  assign cos_stall = !adv;

  // Stage 1: magnitude of the cosine and the index swap for exiting rays.
  logic        v1;
  logic [16:0] c1;
  logic [15:0] ni1, nt1;

  // Stage 2: squares of cosine and both indices.
  logic        v2;
  logic [33:0] cc2;
  logic [31:0] ni2_2, nt2_2;
  logic [16:0] c2;
  logic [15:0] ni_2, nt_2;

  // Stage 3: squared incident sine in Q30.
  logic        v3;
  logic [30:0] s2_3;
  logic [31:0] ni2_3, nt2_3;
  logic [16:0] c3;
  logic [15:0] ni3, nt3;

  // Stage 4: both sides of the Snell test.
  logic        v4;
  logic [62:0] lhs4;
  logic [61:0] rhs4;
  logic [31:0] nt2_4;
  logic [16:0] c4;
  logic [15:0] ni4, nt4;

  // Stage 5: total reflection decision and dividend for the squared
  // transmitted cosine.
  logic        v5;
  logic        tir5;
  logic [61:0] diff5;
  logic [31:0] nt2_5;
  logic [16:0] c5;
  logic [15:0] ni5, nt5;

  always_ff @(posedge clk) begin
    if (adv) begin
      c1  <= cos_incident[15] ? 17'(17'h10000 - {1'b0, cos_incident}) :
                                {1'b0, cos_incident};
      ni1 <= cos_incident[15] ? eta_transmitted : eta_incident;
      nt1 <= cos_incident[15] ? eta_incident : eta_transmitted;

      cc2   <= 34'(c1) * 34'(c1);
      ni2_2 <= 32'(ni1) * 32'(ni1);
      nt2_2 <= 32'(nt1) * 32'(nt1);
      c2    <= c1;
      ni_2  <= ni1;
      nt_2  <= nt1;

      s2_3  <= 31'(34'h040000000 - cc2);
      ni2_3 <= ni2_2;
      nt2_3 <= nt2_2;
      c3    <= c2;
      ni3   <= ni_2;
      nt3   <= nt_2;

      lhs4  <= 63'(ni2_3) * 63'(s2_3);
      rhs4  <= {nt2_3, 30'b0};
      nt2_4 <= nt2_3;
      c4    <= c3;
      ni4   <= ni3;
      nt4   <= nt3;

      // A zero transmitted index makes the right side zero, so it always
      // lands here as total reflection.
      tir5  <= lhs4 >= {1'b0, rhs4};
      diff5 <= 62'({1'b0, rhs4} - lhs4);
      nt2_5 <= nt2_4;
      c5    <= c4;
      ni5   <= ni4;
      nt5   <= nt4;
    end
  end

  // Squared transmitted cosine: t2 = diff / nt^2, then ct = sqrt(t2).
  logic [30:0] t2;
  logic [15:0] ct;

  dfr_div u_div_t2 (
    .clk    (clk),
    .en     (adv),
    .rem_in (34'(diff5[61:31])),
    .lo_in  (diff5[30:0]),
    .dvs_in ({2'b00, nt2_5}),
    .q_out  (t2)
  );

  dfr_sqrt u_sqrt (
    .clk      (clk),
    .en       (adv),
    .v_in     (t2),
    .root_out (ct)
  );

  side_a_t               sa  [0:SIDE_A_LEN-1];
  logic [SIDE_A_LEN-1:0] vda;

  always_ff @(posedge clk) begin
    if (adv) begin
      sa[0] <= '{c: c5, ni: ni5, nt: nt5, tir: tir5};
      for (int i = 1; i < SIDE_A_LEN; i++) begin
        sa[i] <= sa[i-1];
      end
    end
  end

  // Stage 6: the four amplitude products.
  logic        v6;
  logic        tir6;
  logic [32:0] as6, ap6;
  logic [31:0] bs6, bp6;

  // Stage 7: sums and differences of each ratio.
  logic        v7;
  side_b_t     sb7;
  logic [33:0] dens7, denp7;
  logic [32:0] difs7, difp7;

  side_a_t sa_last;
  assign sa_last = sa[SIDE_A_LEN-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      as6  <= 33'(sa_last.nt) * 33'(sa_last.c);
      bs6  <= 32'(sa_last.ni) * 32'(ct);
      ap6  <= 33'(sa_last.ni) * 33'(sa_last.c);
      bp6  <= 32'(sa_last.nt) * 32'(ct);
      tir6 <= sa_last.tir;

      dens7 <= 34'(as6) + 34'(bs6);
      denp7 <= 34'(ap6) + 34'(bp6);
      difs7 <= (as6 >= 33'(bs6)) ? 33'(as6 - 33'(bs6)) : 33'(33'(bs6) - as6);
      difp7 <= (ap6 >= 33'(bp6)) ? 33'(ap6 - 33'(bp6)) : 33'(33'(bp6) - ap6);
      sb7   <= '{tir: tir6,
                 zs: (34'(as6) + 34'(bs6)) == 34'd0,
                 zp: (34'(ap6) + 34'(bp6)) == 34'd0};
    end
  end

  // Ratios |a-b| * 2^30 / (a+b), both in Q30.
  logic [30:0] rs, rp;

  dfr_div u_div_s (
    .clk    (clk),
    .en     (adv),
    .rem_in (34'(difs7[32:1])),
    .lo_in  ({difs7[0], 30'b0}),
    .dvs_in (dens7),
    .q_out  (rs)
  );

  dfr_div u_div_p (
    .clk    (clk),
    .en     (adv),
    .rem_in (34'(difp7[32:1])),
    .lo_in  ({difp7[0], 30'b0}),
    .dvs_in (denp7),
    .q_out  (rp)
  );

  side_b_t               sb  [0:DIV_STAGES-1];
  logic [DIV_STAGES-1:0] vdb;

  always_ff @(posedge clk) begin
    if (adv) begin
      sb[0] <= sb7;
      for (int i = 1; i < DIV_STAGES; i++) begin
        sb[i] <= sb[i-1];
      end
    end
  end

  // Stage 8: squared ratios in Q60; a zero denominator counts as 1.0.
  logic        v8;
  logic        tir8;
  logic [61:0] sqs8, sqp8;

  side_b_t sb_last;
  assign sb_last = sb[DIV_STAGES-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      sqs8 <= sb_last.zs ? 62'h1000000000000000 : 62'(rs) * 62'(rs);
      sqp8 <= sb_last.zp ? 62'h1000000000000000 : 62'(rp) * 62'(rp);
      tir8 <= sb_last.tir;
    end
  end

  // Output register: average, round half up to Q15 and saturate at 1.0.
  logic [62:0] sum8;
  logic [16:0] refl8;
  assign sum8  = 63'(sqs8) + 63'(sqp8) + 63'h0000200000000000;
  assign refl8 = sum8[62:46];

  always_ff @(posedge clk) begin
    if (adv) begin
      if (tir8) begin
        reflectance      <= ONE_Q15;
        total_reflection <= 1'b1;
      end else begin
        reflectance      <= (refl8 > {1'b0, ONE_Q15}) ? ONE_Q15 : refl8[15:0];
        total_reflection <= 1'b0;
      end
    end
  end

  // Valid bits, cleared by reset and moved with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1         <= 1'b0;
      v2         <= 1'b0;
      v3         <= 1'b0;
      v4         <= 1'b0;
      v5         <= 1'b0;
      vda        <= '0;
      v6         <= 1'b0;
      v7         <= 1'b0;
      vdb        <= '0;
      v8         <= 1'b0;
      refl_valid <= 1'b0;
    end else if (adv) begin
      v1         <= cos_valid;
      v2         <= v1;
      v3         <= v2;
      v4         <= v3;
      v5         <= v4;
      vda        <= {vda[SIDE_A_LEN-2:0], v5};
      v6         <= vda[SIDE_A_LEN-1];
      v7         <= v6;
      vdb        <= {vdb[DIV_STAGES-2:0], v7};
      v8         <= vdb[DIV_STAGES-1];
      refl_valid <= v8;
    end
  end

  // A total reflection word always carries exactly 1.0.
  a_tir_one: assert property (@(posedge clk) disable iff (rst)
    refl_valid && total_reflection |-> reflectance == ONE_Q15)
    else $error("total reflection word without full reflectance");

  // Saturation keeps every word at or below 1.0.
  a_sat: assert property (@(posedge clk) disable iff (rst)
    refl_valid |-> reflectance <= ONE_Q15)
    else $error("reflectance above 1.0");

  // A reset leaves the output empty.
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !refl_valid)
    else $error("output valid right after reset");

  // While the input is held off, no word moves inside the divider chains.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    cos_stall |=> $stable(vda) && $stable(vdb))
    else $error("pipeline moved during a stall");

endmodule

[tb/dielectric_fresnel_reflectance_tb.sv]
// Self-checking testbench of the dielectric Fresnel reflectance pipeline.
module dielectric_fresnel_reflectance_tb;
  import dfr_pkg::*;

  // A config index that no register answers to; a write there must change nothing.
  localparam logic [1:0] REG_NONE = 2'd2;
  // This much quiet after the last expected word is enough to drain the pipeline.
  localparam int DRAIN_CYCLES = 120;
  // Cycles with no accepted word before the run is declared hung.
  localparam int HANG_LIMIT = 20000;
  localparam int RANDOM_PER_PHASE = 55;

  typedef struct {
    logic [15:0] refl;
    logic        tir;
  } refl_word_t;

  typedef struct {
    logic [15:0] cos;
    bit          typed;
    logic [15:0] refl;
    logic        tir;
  } directed_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;
  logic               cos_valid = 1'b0;
  logic               cos_stall;
  logic signed [15:0] cos_incident = '0;
  logic               refl_valid;
  logic               refl_stall = 1'b0;
  logic [15:0]        reflectance;
  logic               total_reflection;

  // Our own copy of the two index registers.
  logic [15:0] eta_i_model;
  logic [15:0] eta_t_model;

  refl_word_t pending_refl[$];
  int errors = 0;
  int words_sent = 0;
  int tx_idle_pct = 24;
  int rx_idle_pct = 72;
  int quiet_cycles = 0;

  dielectric_fresnel_reflectance DUT (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cos_valid(cos_valid), .cos_stall(cos_stall), .cos_incident(cos_incident),
    .refl_valid(refl_valid), .refl_stall(refl_stall),
    .reflectance(reflectance), .total_reflection(total_reflection)
  );

  always #5 clk = ~clk;

  // Floor of the square root, one result bit per pass.
  function automatic bit [63:0] floor_sqrt(bit [63:0] v);
    bit [63:0] root;
    bit [63:0] trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // Squared ratio |a-b|/(a+b) in Q60; an empty denominator counts as 1.0.
  function automatic bit [63:0] ratio_squared(bit [63:0] a, bit [63:0] b);
    bit [63:0] den;
    bit [63:0] dif;
    bit [63:0] r;
    den = a + b;
    dif = (a >= b) ? a - b : b - a;
    if (den == 0) return 64'd1 << 60;
    r = (dif << 30) / den;
    return r * r;
  endfunction

  function automatic refl_word_t fresnel_reflectance(logic [15:0] raw);
    refl_word_t w;
    bit [63:0] c, ni, nt, s2, lhs, rhs, t2, ct, sum, refl;
    // A ray leaving the material sees the indices the other way round.
    if (raw[15]) begin
      c = 64'd65536 - 64'(raw);
      ni = 64'(eta_t_model);
      nt = 64'(eta_i_model);
    end else begin
      c = 64'(raw);
      ni = 64'(eta_i_model);
      nt = 64'(eta_t_model);
    end
    s2 = (64'd1 << 30) - c * c;
    lhs = ni * ni * s2;
    rhs = (nt * nt) << 30;
    if (lhs >= rhs) begin
      w.refl = ONE_Q15;
      w.tir = 1'b1;
      return w;
    end
    t2 = (rhs - lhs) / (nt * nt);
    ct = floor_sqrt(t2);
    sum = ratio_squared(nt * c, ni * ct) + ratio_squared(ni * c, nt * ct);
    refl = (sum + (64'd1 << 45)) >> 46;
    if (refl > 64'(ONE_Q15)) refl = 64'(ONE_Q15);
    w.refl = refl[15:0];
    w.tir = 1'b0;
    return w;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == REG_ETA_INCIDENT) eta_i_model = val;
    else if (idx == REG_ETA_TRANSMITTED) eta_t_model = val;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Waits until every expected word has come back and the pipe has drained.
  task automatic drain;
    while (pending_refl.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Idling of both sides depends on how far the run has got: receiver slow first,
  // then the sender slow, then both at full rate.
  task automatic pick_idling;
    if (words_sent < 140) begin
      tx_idle_pct = 24;
      rx_idle_pct = 72;
    end else if (words_sent < 280) begin
      tx_idle_pct = 72;
      rx_idle_pct = 24;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
  endtask

  // Presents one word and holds it until the block takes it. An expectation
  // typed into the table replaces the computed one.
  task automatic send_cos(logic [15:0] raw, bit typed, refl_word_t typed_w);
    bit taken;
    pick_idling();
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      cos_valid <= 1'b0;
    end
    @(negedge clk);
    cos_valid <= 1'b1;
    cos_incident <= raw;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !cos_stall;
    end
    pending_refl.push_back(typed ? typed_w : fresnel_reflectance(raw));
    words_sent++;
  endtask

  task automatic send_random_words(int n);
    logic [15:0] raw;
    refl_word_t none;
    none = '{16'd0, 1'b0};
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(3))
        0: raw = 16'($urandom_range(0, 64));
        1: raw = 16'h8000 + 16'($urandom_range(0, 64));
        2: raw = 16'h7FFF - 16'($urandom_range(0, 64));
        default: raw = 16'($urandom_range(0, 65535));
      endcase
      send_cos(raw, 1'b0, none);
    end
    @(negedge clk);
    cos_valid <= 1'b0;
  endtask

  // Receiver stall, redrawn at every falling edge.
  always @(negedge clk) begin
    refl_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  // Scoreboard: each word taken from the block is checked against the oldest
  // expectation.
  always @(posedge clk) begin
    refl_word_t w;
    if (!rst && refl_valid && !refl_stall) begin
      if (pending_refl.size() == 0) begin
        $error("unexpected word: reflectance=%0d total_reflection=%0b",
               reflectance, total_reflection);
        errors++;
      end else begin
        w = pending_refl.pop_front();
        if (reflectance !== w.refl) begin
          $error("reflectance: expected %0d, actual %0d", w.refl, reflectance);
          errors++;
        end
        if (total_reflection !== w.tir) begin
          $error("total_reflection: expected %0b, actual %0b", w.tir, total_reflection);
          errors++;
        end
      end
    end
  end

  // Hang watchdog: counts cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if ((cos_valid && !cos_stall) || (refl_valid && !refl_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    // Directed words under the reset indices (1.0 incident, 1.5 transmitted).
    // Grazing incidence at cosine zero: both ratios are one. Leaving the
    // dense side at a grazing angle is total reflection.
    directed_row_t rows[] = '{
      '{16'h0000, 1'b1, 16'h8000, 1'b0},
      '{16'hFFFF, 1'b1, 16'h8000, 1'b1},
      '{16'h8001, 1'b0, 16'h0000, 1'b0},
      '{16'h8000, 1'b0, 16'h0000, 1'b0},
      '{16'h7FFF, 1'b0, 16'h0000, 1'b0},
      '{16'h0001, 1'b0, 16'h0000, 1'b0},
      '{16'h4000, 1'b0, 16'h0000, 1'b0},
      '{16'hC000, 1'b0, 16'h0000, 1'b0},
      '{16'h5555, 1'b0, 16'h0000, 1'b0},
      '{16'hAAAA, 1'b0, 16'h0000, 1'b0},
      '{16'hB000, 1'b0, 16'h0000, 1'b0},
      '{16'h1234, 1'b0, 16'h0000, 1'b0}
    };
    // Index settings walked after the directed part: equal indices, both
    // extremes, a zero index on either side, and a random pair.
    logic [15:0] eta_sets[6][2] = '{
      '{16'd4096, 16'd4096},
      '{16'hFFFF, 16'd1},
      '{16'd1, 16'hFFFF},
      '{16'd0, 16'd6144},
      '{16'd4096, 16'd0},
      '{16'd5461, 16'd5000}
    };
    refl_word_t typed_w;

    eta_i_model = ETA_I_RESET;
    eta_t_model = ETA_T_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      typed_w = '{rows[i].refl, rows[i].tir};
      send_cos(rows[i].cos, rows[i].typed, typed_w);
    end
    @(negedge clk);
    cos_valid <= 1'b0;
    send_random_words(RANDOM_PER_PHASE - 10);

    foreach (eta_sets[p]) begin
      drain();
      if (p == 5) begin
        eta_sets[p][0] = 16'($urandom_range(1, 65535));
        eta_sets[p][1] = 16'($urandom_range(1, 65535));
      end
      write_reg(REG_ETA_INCIDENT, eta_sets[p][0]);
      write_reg(REG_ETA_TRANSMITTED, eta_sets[p][1]);
      // A stray write to an unused index must leave both indices alone.
      write_reg(REG_NONE, 16'($urandom_range(0, 65535)));
      send_cos(16'h8000, 1'b0, typed_w);
      send_cos(16'h0000, 1'b0, typed_w);
      send_random_words(RANDOM_PER_PHASE);
    end

    drain();
    if (pending_refl.size() != 0) begin
      $error("%0d expected words never arrived", pending_refl.size());
      errors++;
    end
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
